>>> hdl/slcan_pkg.sv
package slcan_pkg;

	localparam int unsigned MAX_DATA_BYTES = 8;

	localparam logic [7:0] CHAR_LF        = 8'h0A;
	localparam logic [7:0] CHAR_CR        = 8'h0D;
	localparam logic [7:0] CHAR_STD       = 8'h74;  // 't'
	localparam logic [7:0] CHAR_EXT       = 8'h54;  // 'T'
	localparam logic [7:0] CHAR_ZERO      = 8'h30;  // '0'
	localparam logic [7:0] CHAR_NINE      = 8'h39;
	localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
	localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
	localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
	localparam logic [7:0] CHAR_UPPER_F   = 8'h46;

	localparam logic [4:0] STD_ID_DIGITS  = 5'd3;
	localparam logic [4:0] EXT_ID_DIGITS  = 5'd8;
	localparam logic [7:0] MAX_LEN_CHAR   = CHAR_ZERO + 8'(MAX_DATA_BYTES);

	typedef enum logic [2:0] {
		PH_START,
		PH_ID,
		PH_LEN,
		PH_DATA,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_digit_t;

	function automatic hex_digit_t hex_decode(input logic [7:0] c);
		hex_digit_t r;
		logic [7:0] d;
		r = '0;
		d = '0;
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			d = c - CHAR_ZERO;
			r.ok = 1'b1;
			r.val = d[3:0];
		end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
			d = c - CHAR_LOWER_A + 8'd10;
			r.ok = 1'b1;
			r.val = d[3:0];
		end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
			d = c - CHAR_UPPER_A + 8'd10;
			r.ok = 1'b1;
			r.val = d[3:0];
		end
		return r;
	endfunction

endpackage

>>> hdl/slcan_text_line_frame_parser_top.sv
// A byte accepted into the input stage is parsed from there into the line state; a newline
// that closes a valid line loads its frame into the output register as it leaves the input
// stage, and that stage waits while the output register holds a frame not yet taken.
// Throughput: one byte per cycle outside such waits; line state: one pass of nibble logic.
// Reset (arst_n low, asynchronous): both stages empty, parser waits for a line start.
module slcan_text_line_frame_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  ascii_char,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        extended_frame,
	output logic [31:0] identifier,
	output logic [3:0]  length,
	output logic [7:0]  data_byte_0,
	output logic [7:0]  data_byte_1,
	output logic [7:0]  data_byte_2,
	output logic [7:0]  data_byte_3,
	output logic [7:0]  data_byte_4,
	output logic [7:0]  data_byte_5,
	output logic [7:0]  data_byte_6,
	output logic [7:0]  data_byte_7
);
	import slcan_pkg::*;

	// Input stage.
	logic       valid_s1;
	logic [7:0] char_s1;

	// Line state.
	phase_t      phase_q, phase_d;
	logic [4:0]  digit_cnt_q, digit_cnt_d;
	logic [31:0] id_q, id_d;
	logic        ext_q, ext_d;
	logic [3:0]  len_q, len_d;
	logic [63:0] data_q, data_d;
	logic        bad_q, bad_d;

	// Output register.
	logic        out_valid_q;
	logic        ext_out_q;
	logic [31:0] id_out_q;
	logic [3:0]  len_out_q;
	logic [63:0] data_out_q;

	logic       emit;
	logic       out_free;
	logic       advance;
	hex_digit_t hex;
	logic [4:0] cnt_inc;
	logic [4:0] id_target;
	logic [7:0] len_val;
	logic [3:0] nib_idx;

	assign hex       = hex_decode(char_s1);
	assign cnt_inc   = digit_cnt_q + 5'd1;
	assign id_target = ext_q ? EXT_ID_DIGITS : STD_ID_DIGITS;
	assign len_val   = char_s1 - CHAR_ZERO;
	// High nibble of a byte comes first, so even digits land in the upper nibble.
	assign nib_idx   = {digit_cnt_q[3:1], ~digit_cnt_q[0]};

	// Output-side decisions for the byte in the input stage.
	always_comb begin
		emit = valid_s1 && (char_s1 == CHAR_LF) && !bad_q && (phase_q == PH_DONE);
	end

	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && (!emit || out_free);
	assign in_ready = !valid_s1 || advance;

	// Next line state.
	always_comb begin
		phase_d     = phase_q;
		digit_cnt_d = digit_cnt_q;
		id_d        = id_q;
		ext_d       = ext_q;
		len_d       = len_q;
		data_d      = data_q;
		bad_d       = bad_q;
		if (char_s1 == CHAR_LF) begin
			phase_d     = PH_START;
			digit_cnt_d = '0;
			id_d        = '0;
			ext_d       = 1'b0;
			len_d       = '0;
			data_d      = '0;
			bad_d       = 1'b0;
		end else if (char_s1 != CHAR_CR && !bad_q) begin
			case (phase_q)
				PH_START: begin
					if (char_s1 == CHAR_STD || char_s1 == CHAR_EXT) begin
						ext_d       = (char_s1 == CHAR_EXT);
						id_d        = '0;
						digit_cnt_d = '0;
						data_d      = '0;
						phase_d     = PH_ID;
					end else begin
						bad_d = 1'b1;
					end
				end
				PH_ID: begin
					if (!hex.ok) begin
						bad_d = 1'b1;
					end else begin
						id_d        = {id_q[27:0], hex.val};
						digit_cnt_d = cnt_inc;
						if (cnt_inc >= id_target) begin
							digit_cnt_d = '0;
							phase_d     = PH_LEN;
						end
					end
				end
				PH_LEN: begin
					if (char_s1 < CHAR_ZERO || char_s1 > CHAR_NINE || char_s1 > MAX_LEN_CHAR) begin
						bad_d = 1'b1;
					end else begin
						len_d       = len_val[3:0];
						digit_cnt_d = '0;
						phase_d     = (len_val[3:0] == 4'd0) ? PH_DONE : PH_DATA;
					end
				end
				PH_DATA: begin
					if (!hex.ok) begin
						bad_d = 1'b1;
					end else begin
						data_d[nib_idx*4 +: 4] = data_q[nib_idx*4 +: 4] | hex.val;
						digit_cnt_d = cnt_inc;
						if (cnt_inc >= {len_q, 1'b0})
							phase_d = PH_DONE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			char_s1 <= ascii_char;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			digit_cnt_q <= '0;
			id_q        <= '0;
			ext_q       <= 1'b0;
			len_q       <= '0;
			data_q      <= '0;
			bad_q       <= 1'b0;
		end else if (advance) begin
			phase_q     <= phase_d;
			digit_cnt_q <= digit_cnt_d;
			id_q        <= id_d;
			ext_q       <= ext_d;
			len_q       <= len_d;
			data_q      <= data_d;
			bad_q       <= bad_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			ext_out_q  <= ext_q;
			id_out_q   <= id_q;
			len_out_q  <= len_q;
			data_out_q <= data_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign extended_frame = ext_out_q;
	assign identifier     = id_out_q;
	assign length         = len_out_q;
	assign data_byte_0    = data_out_q[7:0];
	assign data_byte_1    = data_out_q[15:8];
	assign data_byte_2    = data_out_q[23:16];
	assign data_byte_3    = data_out_q[31:24];
	assign data_byte_4    = data_out_q[39:32];
	assign data_byte_5    = data_out_q[47:40];
	assign data_byte_6    = data_out_q[55:48];
	assign data_byte_7    = data_out_q[63:56];

endmodule

>>> hdl/slcan_checker.sv
module slcan_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [7:0]  ascii_char,
	input logic        out_valid,
	input logic        out_ready,
	input logic        extended_frame,
	input logic [31:0] identifier,
	input logic [3:0]  length,
	input logic [7:0]  data_byte_7
);
	import slcan_pkg::*;

	// An offered input beat stays put until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(ascii_char))
		else $error("input beat changed while stalled");

	// A stalled result beat stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(identifier) && $stable(length))
		else $error("result beat changed while stalled");

	// A frame never claims more data bytes than a line may carry.
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> length <= 4'(MAX_DATA_BYTES))
		else $error("frame length out of range");

	// A standard frame has only three identifier digits.
	a_std_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !extended_frame |-> identifier[31:12] == 20'd0)
		else $error("standard identifier wider than 12 bits");

	// Unused trailing data byte reads as zero.
	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && length < 4'd8 |-> data_byte_7 == 8'd0)
		else $error("unused data byte not zero");

endmodule

bind slcan_text_line_frame_parser_top slcan_checker u_slcan_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.ascii_char     (ascii_char),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.extended_frame (extended_frame),
	.identifier     (identifier),
	.length         (length),
	.data_byte_7    (data_byte_7)
);

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import slcan_pkg::*;

	localparam int RANDOM_CHARS   = 1150;
	localparam int MIN_FRAMES     = 40;
	localparam int IDLE_PERCENT   = 38;
	localparam int LONG_STALL     = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 20;

	typedef struct packed {
		logic            ext;
		logic [31:0]     id;
		logic [3:0]      len;
		logic [7:0][7:0] payload;
	} frame_t;

	// Tracks the line state the parser should hold and the frames it owes.
	class slcan_frame_board;
		phase_t      phase;
		logic [4:0]  ndigits;
		logic [31:0] id_acc;
		logic        ext;
		logic [3:0]  flen;
		logic [63:0] data_acc;
		logic        discard;
		frame_t      expected_frames[$];
		int          frames_predicted;
		int          mismatches;

		function new();
			clear_line();
			frames_predicted = 0;
			mismatches = 0;
		endfunction

		function void clear_line();
			phase = PH_START;
			ndigits = '0;
			id_acc = '0;
			ext = 1'b0;
			flen = '0;
			data_acc = '0;
			discard = 1'b0;
		endfunction

		function int nibble_of(logic [7:0] c);
			if (c >= CHAR_ZERO && c <= CHAR_NINE)
				return int'(c - CHAR_ZERO);
			if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F)
				return int'(c - CHAR_LOWER_A) + 10;
			if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)
				return int'(c - CHAR_UPPER_A) + 10;
			return -1;
		endfunction

		function void note_char(logic [7:0] c);
			frame_t f;
			int nib;
			int shift;
			if (c == CHAR_LF) begin
				if (!discard && phase == PH_DONE) begin
					f.ext = ext;
					f.id = id_acc;
					f.len = flen;
					f.payload = data_acc;
					expected_frames.push_back(f);
					frames_predicted++;
				end
				clear_line();
				return;
			end
			if (c == CHAR_CR || discard)
				return;
			case (phase)
				PH_START: begin
					if (c == CHAR_STD)
						ext = 1'b0;
					else if (c == CHAR_EXT)
						ext = 1'b1;
					else begin
						discard = 1'b1;
						return;
					end
					id_acc = '0;
					ndigits = '0;
					data_acc = '0;
					phase = PH_ID;
				end
				PH_ID: begin
					nib = nibble_of(c);
					if (nib < 0) begin
						discard = 1'b1;
						return;
					end
					id_acc = {id_acc[27:0], 4'(nib)};
					ndigits++;
					if (ndigits >= (ext ? EXT_ID_DIGITS : STD_ID_DIGITS)) begin
						ndigits = '0;
						phase = PH_LEN;
					end
				end
				PH_LEN: begin
					if (c < CHAR_ZERO || c > MAX_LEN_CHAR) begin
						discard = 1'b1;
						return;
					end
					flen = 4'(c - CHAR_ZERO);
					ndigits = '0;
					phase = (flen == 0) ? PH_DONE : PH_DATA;
				end
				PH_DATA: begin
					nib = nibble_of(c);
					if (nib < 0) begin
						discard = 1'b1;
						return;
					end
					// High nibble of each byte comes first.
					shift = int'(ndigits[3:1]) * 8 + (ndigits[0] ? 0 : 4);
					data_acc |= 64'(nib) << shift;
					ndigits++;
					if (ndigits >= 5'(2 * flen))
						phase = PH_DONE;
				end
				default: ;
			endcase
		endfunction

		function void flag(string what, logic [63:0] want, logic [63:0] seen);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, seen);
		endfunction

		function void check_frame(frame_t got);
			frame_t want;
			if (expected_frames.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: frame with id %0h arrived with none expected",
						$time, got.id);
				return;
			end
			want = expected_frames.pop_front();
			if (want.ext !== got.ext)
				flag("extended_frame", want.ext, got.ext);
			if (want.id !== got.id)
				flag("identifier", want.id, got.id);
			if (want.len !== got.len)
				flag("length", want.len, got.len);
			for (int k = 0; k < 8; k++)
				if (want.payload[k] !== got.payload[k])
					flag($sformatf("data_byte_%0d", k), want.payload[k], got.payload[k]);
		endfunction

		function int pending();
			return expected_frames.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  ascii_char;
	logic        out_valid;
	logic        out_ready;
	logic        extended_frame;
	logic [31:0] identifier;
	logic [3:0]  length;
	logic [7:0]  data_byte_0;
	logic [7:0]  data_byte_1;
	logic [7:0]  data_byte_2;
	logic [7:0]  data_byte_3;
	logic [7:0]  data_byte_4;
	logic [7:0]  data_byte_5;
	logic [7:0]  data_byte_6;
	logic [7:0]  data_byte_7;

	slcan_frame_board board = new();
	logic [7:0]       line_buf[$];
	int               chars_sent = 0;
	bit               steady_flow = 1'b0;
	int               stall_request = 0;

	slcan_text_line_frame_parser_top uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.ascii_char     (ascii_char),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.extended_frame (extended_frame),
		.identifier     (identifier),
		.length         (length),
		.data_byte_0    (data_byte_0),
		.data_byte_1    (data_byte_1),
		.data_byte_2    (data_byte_2),
		.data_byte_3    (data_byte_3),
		.data_byte_4    (data_byte_4),
		.data_byte_5    (data_byte_5),
		.data_byte_6    (data_byte_6),
		.data_byte_7    (data_byte_7)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side: checks each accepted beat and decides out_ready for the next edge.
	initial begin
		frame_t got;
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got.ext = extended_frame;
				got.id = identifier;
				got.len = length;
				got.payload = {data_byte_7, data_byte_6, data_byte_5, data_byte_4,
					data_byte_3, data_byte_2, data_byte_1, data_byte_0};
				board.check_frame(got);
			end
			if (stall_request > 0) begin
				hold_left = stall_request;
				stall_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic send_char(input logic [7:0] c);
		while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		ascii_char <= c;
		do
			@(posedge clk);
		while (!in_ready);
		board.note_char(c);
		chars_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	task automatic drain_frames();
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] hex_char(logic [3:0] v);
		if (v < 10)
			return CHAR_ZERO + 8'(v);
		return ($urandom_range(1) ? CHAR_UPPER_A : CHAR_LOWER_A) + 8'(v) - 8'd10;
	endfunction

	// Mostly well-formed lines with random content; the rest is noise,
	// corrupted characters and lines cut short.
	task automatic build_line();
		int roll;
		int len;
		int cut;
		bit ext;
		line_buf.delete();
		roll = $urandom_range(99);
		if (roll < 15) begin
			repeat ($urandom_range(1, 12))
				line_buf.push_back(8'($urandom_range(255)));
			if ($urandom_range(1))
				line_buf.push_back(CHAR_LF);
			return;
		end
		ext = 1'($urandom_range(1));
		line_buf.push_back(ext ? CHAR_EXT : CHAR_STD);
		repeat (ext ? 8 : 3)
			line_buf.push_back(hex_char(4'($urandom_range(15))));
		len = $urandom_range(MAX_DATA_BYTES);
		line_buf.push_back(CHAR_ZERO + 8'(len));
		repeat (2 * len)
			line_buf.push_back(hex_char(4'($urandom_range(15))));
		if ($urandom_range(99) < 15)
			repeat ($urandom_range(1, 6))
				line_buf.push_back(8'($urandom_range(32, 126)));
		if (roll >= 85 && roll < 92) begin
			line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom_range(255));
		end else if (roll >= 92) begin
			cut = $urandom_range(1, line_buf.size() - 1);
			repeat (cut)
				void'(line_buf.pop_back());
		end
		if ($urandom_range(99) < 10)
			line_buf.insert($urandom_range(line_buf.size()), CHAR_CR);
		line_buf.push_back(CHAR_LF);
	endtask

	initial begin
		int random_sent;
		bit stalled;
		bit paused;
		arst_n = 1'b0;
		in_valid = 1'b0;
		ascii_char = '0;
		stalled = 1'b0;
		paused = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_char(CHAR_LF);
		send_text("t0000");
		send_char(CHAR_LF);
		send_text("TffffFFFF8FFff");
		send_char(CHAR_CR);
		send_text("FFffFFffFFff");
		send_char(CHAR_LF);
		// Trailing timestamp after the last data digit.
		send_text("t7FF1a5 99");
		send_char(CHAR_LF);
		send_text("x1");
		send_char(CHAR_LF);
		send_text("t123");
		send_char(8'h00);
		send_char(CHAR_LF);
		send_text("t1239");
		send_char(CHAR_LF);
		send_text("t12321");
		send_char(CHAR_LF);
		drain_frames();

		random_sent = 0;
		while (random_sent < RANDOM_CHARS || board.frames_predicted < MIN_FRAMES) begin
			steady_flow = (random_sent >= 300 && random_sent < 500);
			if (!stalled && random_sent >= 700) begin
				stalled = 1'b1;
				stall_request = LONG_STALL;
			end
			if (!paused && random_sent >= 900) begin
				paused = 1'b1;
				drain_frames();
			end
			build_line();
			foreach (line_buf[i]) begin
				send_char(line_buf[i]);
				random_sent++;
			end
		end
		in_valid <= 1'b0;
		steady_flow = 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
